>>> rtl/three_plane_intersection_defines.svh
// Assertion macros shared by the three-plane intersection RTL.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef THREE_PLANE_INTERSECTION_DEFINES_SVH
`define THREE_PLANE_INTERSECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TPI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/tpi_pkg.sv
// Shared widths and latencies for the three-plane intersection block.
// No dependencies.
`default_nettype none
package tpi_pkg;
    localparam int NORM_W   = 18;
    localparam int OFS_W    = 32;
    localparam int PLANE_W  = 3 * NORM_W + OFS_W;
    localparam int IN_W     = 264;
    localparam int OUT_W    = 104;
    localparam int PROD_W   = 2 * NORM_W;
    localparam int COF_W    = PROD_W + 1;
    localparam int DET_W    = 55;
    localparam int DMAG_W   = DET_W - 1;
    localparam int NUM_W    = 69;
    localparam int NMAG_W   = 84;
    localparam int COORD_W  = 32;
    localparam int QBITS    = COORD_W;
    localparam int LANE_LAT = QBITS + 3;
    localparam int FRONT_ST = 5;
    localparam int TOTAL_ST = FRONT_ST + LANE_LAT;
endpackage
`default_nettype wire

>>> rtl/tpi_div_lane.sv
// One coordinate divider: restoring division, one quotient bit per stage,
// then rounding and saturation. Depends on tpi_pkg.
`default_nettype none
module tpi_div_lane (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [tpi_pkg::NMAG_W-1:0]  num_mag,
    input  wire logic [tpi_pkg::DMAG_W-1:0]  den_mag,
    input  wire logic                        neg,
    output logic      [tpi_pkg::COORD_W-1:0] coord,
    output logic                             sat
);
    localparam int DW = tpi_pkg::DMAG_W;
    localparam int QN = tpi_pkg::QBITS;
    localparam int CW = tpi_pkg::COORD_W;
    localparam int NW = tpi_pkg::NMAG_W;

    logic [DW-1:0] r_reg  [QN+1];
    logic [DW-1:0] d_reg  [QN+1];
    logic [QN-1:0] q_reg  [QN+1];
    logic [QN-1:0] lo_reg [QN+1];
    logic          ng_reg [QN+1];
    logic          ov_reg [QN+1];

    logic [CW:0]   qr_reg;
    logic          rov_reg;
    logic          rng_reg;
    logic [CW-1:0] coord_reg;
    logic          sat_reg;

    // Quotient bits at 2^32 and above only mean overflow.
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= DW'(num_mag[NW-1:QN]);
            lo_reg[0] <= num_mag[QN-1:0];
            d_reg[0]  <= den_mag;
            q_reg[0]  <= '0;
            ng_reg[0] <= neg;
            ov_reg[0] <= DW'(num_mag[NW-1:QN]) >= den_mag;
        end
    end

    for (genvar j = 1; j <= QN; j++) begin : g_iter
        logic [DW:0] t;
        logic        ge;
        always_comb begin
            t  = {r_reg[j-1], lo_reg[j-1][QN-1]};
            ge = t >= {1'b0, d_reg[j-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j]  <= ge ? DW'(t - {1'b0, d_reg[j-1]}) : DW'(t);
                q_reg[j]  <= {q_reg[j-1][QN-2:0], ge};
                lo_reg[j] <= {lo_reg[j-1][QN-2:0], 1'b0};
                d_reg[j]  <= d_reg[j-1];
                ng_reg[j] <= ng_reg[j-1];
                ov_reg[j] <= ov_reg[j-1];
            end
        end
    end

    logic half;
    assign half = r_reg[QN] >= (d_reg[QN] - r_reg[QN]);

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg  <= {1'b0, q_reg[QN]} + (CW+1)'(half);
            rov_reg <= ov_reg[QN];
            rng_reg <= ng_reg[QN];
        end
    end

    logic [CW:0] limit;
    logic        over;
    always_comb begin
        limit = rng_reg ? (CW+1)'(1) << (CW-1) : ((CW+1)'(1) << (CW-1)) - 1'b1;
        over  = rov_reg || (qr_reg > limit);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg <= over;
            if (over)
                coord_reg <= limit[CW-1:0];
            else if (rng_reg)
                coord_reg <= CW'(~qr_reg[CW-1:0] + 1'b1);
            else
                coord_reg <= qr_reg[CW-1:0];
        end
    end

    assign coord = coord_reg;
    assign sat   = sat_reg;
endmodule
`default_nettype wire

>>> rtl/three_plane_intersection.sv
// Top level of the three-plane intersection block (Cramer's rule).
// Depends on tpi_pkg, tpi_div_lane and three_plane_intersection_defines.svh.
//
//  channel | dir | tdata                          | tuser
//  s_      | in  | 3 planes {nx,ny,nz,offset}     | -
//  m_      | out | point_x, point_y, point_z, sat | found
//
// One transfer in per cycle unless a result is waiting on m_tready.
// The pipeline is 5 stages of multiply/add for cofactors, determinant and
// numerators, plus a 35-stage divider lane per coordinate (one quotient bit
// per stage). The whole pipeline holds while a result waits on m_tready.
// Reset clears the valid bits only.
`default_nettype none
`include "three_plane_intersection_defines.svh"
module three_plane_intersection (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // plane 0..2, each {nx[17:0], ny, nz, offset[31:0]} from bit 0; pad to 264
    input  wire logic [tpi_pkg::IN_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64], saturated[96], zero pad
    output logic      [tpi_pkg::OUT_W-1:0]  m_tdata,
    // found[0]
    output logic                            m_tuser
);
    localparam int NW  = tpi_pkg::NORM_W;
    localparam int OW  = tpi_pkg::OFS_W;
    localparam int PW  = tpi_pkg::PLANE_W;
    localparam int PRW = tpi_pkg::PROD_W;
    localparam int CFW = tpi_pkg::COF_W;
    localparam int DTW = tpi_pkg::DET_W;
    localparam int NMW = tpi_pkg::NUM_W;
    localparam int TS  = tpi_pkg::TOTAL_ST;
    localparam int FS  = tpi_pkg::FRONT_ST;
    localparam int CW  = tpi_pkg::COORD_W;

    logic en;
    logic vld_reg [1:TS];
    logic fnd_reg [FS:TS];

    assign en       = !vld_reg[TS] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 1; s <= TS; s++) vld_reg[s] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int s = 2; s <= TS; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    logic signed [NW-1:0] n_in [3][3];
    logic signed [OW-1:0] v_in [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) n_in[i][k] = s_tdata[i*PW + k*NW +: NW];
            v_in[i] = s_tdata[i*PW + 3*NW +: OW];
        end
    end

    // Stage 1: cofactor partial products
    logic signed [PRW-1:0] pa_reg [3][3];
    logic signed [PRW-1:0] pb_reg [3][3];
    logic signed [NW-1:0]  n0_reg [3];
    logic signed [OW-1:0]  v1_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    pa_reg[i][k] <= n_in[(i+1)%3][(k+1)%3] * n_in[(i+2)%3][(k+2)%3];
                    pb_reg[i][k] <= n_in[(i+1)%3][(k+2)%3] * n_in[(i+2)%3][(k+1)%3];
                end
                n0_reg[i] <= n_in[0][i];
                v1_reg[i] <= v_in[i];
            end
        end
    end

    // Stage 2: cofactors
    logic signed [CFW-1:0] cof_reg [3][3];
    logic signed [NW-1:0]  n2_reg  [3];
    logic signed [OW-1:0]  v2_reg  [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++)
                    cof_reg[i][k] <= CFW'(pa_reg[i][k]) - CFW'(pb_reg[i][k]);
                n2_reg[i] <= n0_reg[i];
                v2_reg[i] <= v1_reg[i];
            end
        end
    end

    // Stage 3: determinant and numerator terms
    logic signed [DTW-1:0] dt_reg [3];
    logic signed [NMW-1:0] nt_reg [3][3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dt_reg[i] <= DTW'(n2_reg[i] * cof_reg[0][i]);
                for (int k = 0; k < 3; k++)
                    nt_reg[i][k] <= NMW'(v2_reg[i] * cof_reg[i][k]);
            end
        end
    end

    // Stage 4: sums
    logic signed [DTW-1:0] det_reg;
    logic signed [NMW-1:0] num_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= dt_reg[0] + dt_reg[1] + dt_reg[2];
            for (int k = 0; k < 3; k++)
                num_reg[k] <= nt_reg[0][k] + nt_reg[1][k] + nt_reg[2][k];
        end
    end

    // Stage 5: magnitudes and signs; numerator scaled by 2^16
    logic [tpi_pkg::NMAG_W-1:0] nmag_reg [3];
    logic [tpi_pkg::DMAG_W-1:0] dmag_reg;
    logic                       neg_reg  [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg     <= tpi_pkg::DMAG_W'(det_reg[DTW-1] ? -det_reg : det_reg);
            fnd_reg[FS]  <= det_reg != '0;
            for (int k = 0; k < 3; k++) begin
                nmag_reg[k] <= {tpi_pkg::NMAG_W'(num_reg[k][NMW-1] ? -num_reg[k]
                                                               : num_reg[k])} << 16;
                neg_reg[k]  <= num_reg[k][NMW-1] ^ det_reg[DTW-1];
            end
            for (int s = FS + 1; s <= TS; s++) fnd_reg[s] <= fnd_reg[s-1];
        end
    end

    logic [CW-1:0] coord [3];
    logic          csat  [3];
    for (genvar k = 0; k < 3; k++) begin : g_lane
        tpi_div_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .num_mag (nmag_reg[k]),
            .den_mag (dmag_reg),
            .neg     (neg_reg[k]),
            .coord   (coord[k]),
            .sat     (csat[k])
        );
    end

    // Drop the lane results when the normals are singular.
    logic found;
    assign found    = fnd_reg[TS];
    assign m_tvalid = vld_reg[TS];
    assign m_tuser  = found;
    assign m_tdata  = found
        ? {7'b0, csat[0] | csat[1] | csat[2], coord[2], coord[1], coord[0]}
        : '0;

    // Flag when any output coordinate sits at either end of its range.
    logic sat_pinned;
    always_comb begin
        sat_pinned = 1'b0;
        for (int k = 0; k < 3; k++)
            sat_pinned = sat_pinned
                || (m_tdata[k*CW +: CW] == {1'b0, {(CW-1){1'b1}}})
                || (m_tdata[k*CW +: CW] == {1'b1, {(CW-1){1'b0}}});
    end

    `TPI_ASSERT_IMPL(a_singular_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `TPI_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[1])
    `TPI_ASSERT_IMPL(a_sat_extreme, aclk, aresetn, m_tvalid && m_tdata[3*CW], sat_pinned)
endmodule
`default_nettype wire
